@@ rtl/siu_pkg.sv @@
package siu_pkg;

  localparam int CoordBitsDefault = 24;

  localparam logic CmdSegment = 1'b0;
  localparam logic CmdRect    = 1'b1;

endpackage

@@ rtl/siu_div_cell.sv @@
// one radix-2 restoring divide step on two lanes (x and y) sharing a denominator
module siu_div_cell #(
  parameter int NW = 56,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_x_i,
  input  logic [NW-1:0] num_y_i,
  input  logic [NW-1:0] rem_x_i,
  input  logic [NW-1:0] rem_y_i,
  input  logic [QW-1:0] q_x_i,
  input  logic [QW-1:0] q_y_i,
  input  logic [NW-1:0] den_i,
  output logic [NW-1:0] num_x_o,
  output logic [NW-1:0] num_y_o,
  output logic [NW-1:0] rem_x_o,
  output logic [NW-1:0] rem_y_o,
  output logic [QW-1:0] q_x_o,
  output logic [QW-1:0] q_y_o,
  output logic [NW-1:0] den_o
);

  logic [NW:0] tx, ty;
  logic        gx, gy;

  always_comb begin
    tx = {rem_x_i, num_x_i[NW-1]};
    ty = {rem_y_i, num_y_i[NW-1]};
    gx = tx >= {1'b0, den_i};
    gy = ty >= {1'b0, den_i};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_x_o <= {num_x_i[NW-2:0], 1'b0};
      num_y_o <= {num_y_i[NW-2:0], 1'b0};
      rem_x_o <= gx ? NW'(tx - {1'b0, den_i}) : tx[NW-1:0];
      rem_y_o <= gy ? NW'(ty - {1'b0, den_i}) : ty[NW-1:0];
      q_x_o   <= {q_x_i[QW-2:0], gx};
      q_y_o   <= {q_y_i[QW-2:0], gy};
      den_o   <= den_i;
    end
  end

endmodule

@@ rtl/segment_intersect_unit_core.sv @@
// segment intersection unit
// input channel: in_valid / in_stall with command and eight coordinates,
// output channel: out_valid / out_stall with hit and crossing point.
// command 0 tests segment against segment and gives the crossing point,
// command 1 tests the segment against the four rectangle edges, point zero.
// fully pipelined: one request enters per cycle, one result leaves per cycle, while the output is not stalled.
// pipeline: a difference stage, a product stage, a cross product stage, a
// sign/compare stage with split numerator products, a numerator sum stage,
// then a row of COORD_BITS+2 divide cells (one quotient bit each) that form
// t*r/D for both axes, then the output register.
// the whole pipe advances only when the output register is free or taken,
// so a stalled result holds and in_stall follows out_stall.
// reset clears all valid bits; payload is left untouched.
module segment_intersect_unit_core #(
  parameter int COORD_BITS = siu_pkg::CoordBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_command,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_other_x0,
  input  logic signed [COORD_BITS-1:0] in_other_y0,
  input  logic signed [COORD_BITS-1:0] in_other_x1,
  input  logic signed [COORD_BITS-1:0] in_other_y1,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_hit,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y
);

  localparam int CW = COORD_BITS;
  // differences up to CW+2 bits (rect corners are one bit wider)
  localparam int DW = CW + 3;
  localparam int PW = 2 * DW;
  // magnitude of t*r, numerator below D * 2^(CW+1)
  localparam int NW = PW + CW + 1;
  // partial product of one half of the t numerator and |r|
  localparam int MW = DW + CW + 1;
  localparam int QW = CW + 2;
  localparam int NCELL = QW;
  localparam int LAT = 6 + NCELL;

  logic adv;
  assign adv = !out_valid || !out_stall;
  assign in_stall = !adv;

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
  end
  assign out_valid = vld_r[LAT-1];

  // ---- stage 1: edge endpoints and differences for all five tests
  typedef logic signed [DW-1:0] d_t;
  d_t ax, ay, bx, by, o0, o1, o2, o3, rr, bb;
  d_t cx [5], cy [5], ex [5], ey [5];
  always_comb begin
    ax = DW'(in_start_x); ay = DW'(in_start_y);
    bx = DW'(in_end_x);   by = DW'(in_end_y);
    o0 = DW'(in_other_x0); o1 = DW'(in_other_y0);
    o2 = DW'(in_other_x1); o3 = DW'(in_other_y1);
    rr = o0 + o2; bb = o1 + o3;
    // lane 0: segment, lanes 1..4: top, right, bottom, left
    cx[0] = o0; cy[0] = o1; ex[0] = o2; ey[0] = o3;
    cx[1] = o0; cy[1] = o1; ex[1] = rr; ey[1] = o1;
    cx[2] = rr; cy[2] = o1; ex[2] = rr; ey[2] = bb;
    cx[3] = rr; cy[3] = bb; ex[3] = o0; ey[3] = bb;
    cx[4] = o0; cy[4] = bb; ex[4] = o0; ey[4] = o1;
  end

  logic s1_cmd_r;
  d_t s1_ax_r, s1_ay_r, s1_rx_r, s1_ry_r;
  d_t s1_sx_r [5], s1_sy_r [5], s1_wx_r [5], s1_wy_r [5];
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r <= in_command;
      s1_ax_r <= ax; s1_ay_r <= ay;
      s1_rx_r <= bx - ax; s1_ry_r <= by - ay;
      for (int i = 0; i < 5; i++) begin
        s1_sx_r[i] <= ex[i] - cx[i];
        s1_sy_r[i] <= ey[i] - cy[i];
        s1_wx_r[i] <= cx[i] - ax;
        s1_wy_r[i] <= cy[i] - ay;
      end
    end
  end

  // ---- stage 2: products
  typedef logic signed [PW-1:0] p_t;
  p_t s2_p [5][6];
  logic s2_cmd_r;
  d_t s2_ax_r, s2_ay_r, s2_rx_r, s2_ry_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_cmd_r <= s1_cmd_r;
      s2_ax_r <= s1_ax_r; s2_ay_r <= s1_ay_r;
      s2_rx_r <= s1_rx_r; s2_ry_r <= s1_ry_r;
      for (int i = 0; i < 5; i++) begin
        s2_p[i][0] <= s1_rx_r * s1_sy_r[i];
        s2_p[i][1] <= s1_ry_r * s1_sx_r[i];
        s2_p[i][2] <= s1_wx_r[i] * s1_sy_r[i];
        s2_p[i][3] <= s1_wy_r[i] * s1_sx_r[i];
        s2_p[i][4] <= s1_wx_r[i] * s1_ry_r;
        s2_p[i][5] <= s1_wy_r[i] * s1_rx_r;
      end
    end
  end

  // ---- stage 3: cross products
  typedef logic signed [PW:0] c_t;
  c_t s3_den_r [5], s3_nt_r [5], s3_nu_r [5];
  logic s3_cmd_r;
  d_t s3_ax_r, s3_ay_r, s3_rx_r, s3_ry_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_cmd_r <= s2_cmd_r;
      s3_ax_r <= s2_ax_r; s3_ay_r <= s2_ay_r;
      s3_rx_r <= s2_rx_r; s3_ry_r <= s2_ry_r;
      for (int i = 0; i < 5; i++) begin
        s3_den_r[i] <= (PW+1)'(s2_p[i][0]) - (PW+1)'(s2_p[i][1]);
        s3_nt_r[i]  <= (PW+1)'(s2_p[i][2]) - (PW+1)'(s2_p[i][3]);
        s3_nu_r[i]  <= (PW+1)'(s2_p[i][4]) - (PW+1)'(s2_p[i][5]);
      end
    end
  end

  // ---- stage 4: hit tests, numerator as two partial products
  logic [4:0] lane_hit;
  c_t dn [5], tn [5], un [5];
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      dn[i] = s3_den_r[i][PW] ? -s3_den_r[i] : s3_den_r[i];
      tn[i] = s3_den_r[i][PW] ? -s3_nt_r[i]  : s3_nt_r[i];
      un[i] = s3_den_r[i][PW] ? -s3_nu_r[i]  : s3_nu_r[i];
      lane_hit[i] = (s3_den_r[i] != '0) && !tn[i][PW] && !un[i][PW]
                    && (tn[i] <= dn[i]) && (un[i] <= dn[i]);
    end
  end

  logic [CW:0] mrx, mry;
  assign mrx = s3_rx_r[DW-1] ? (CW+1)'(-s3_rx_r) : (CW+1)'(s3_rx_r);
  assign mry = s3_ry_r[DW-1] ? (CW+1)'(-s3_ry_r) : (CW+1)'(s3_ry_r);

  logic s4_hit_r, s4_pt_r, s4_nx_r, s4_ny_r;
  logic [MW-1:0] s4_plx_r, s4_phx_r, s4_ply_r, s4_phy_r;
  logic [NW-1:0] s4_den_r;
  d_t s4_ax_r, s4_ay_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_hit_r  <= (s3_cmd_r == siu_pkg::CmdSegment) ? lane_hit[0] : |lane_hit[4:1];
      s4_pt_r   <= (s3_cmd_r == siu_pkg::CmdSegment) && lane_hit[0];
      s4_nx_r   <= s3_rx_r[DW-1];
      s4_ny_r   <= s3_ry_r[DW-1];
      // low and high halves of t's numerator times |r|
      s4_plx_r  <= MW'(tn[0][DW-1:0]) * MW'(mrx);
      s4_phx_r  <= MW'(tn[0][PW-1:DW]) * MW'(mrx);
      s4_ply_r  <= MW'(tn[0][DW-1:0]) * MW'(mry);
      s4_phy_r  <= MW'(tn[0][PW-1:DW]) * MW'(mry);
      s4_den_r  <= NW'(dn[0][PW-1:0]);
      s4_ax_r   <= s3_ax_r; s4_ay_r <= s3_ay_r;
    end
  end

  // ---- stage 5: full numerator from the two partial products
  logic s5_hit_r, s5_pt_r, s5_nx_r, s5_ny_r;
  logic [NW-1:0] s5_numx_r, s5_numy_r, s5_den_r;
  d_t s5_ax_r, s5_ay_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_hit_r  <= s4_hit_r;
      s5_pt_r   <= s4_pt_r;
      s5_nx_r   <= s4_nx_r;
      s5_ny_r   <= s4_ny_r;
      s5_numx_r <= {s4_phx_r, {DW{1'b0}}} + NW'(s4_plx_r);
      s5_numy_r <= {s4_phy_r, {DW{1'b0}}} + NW'(s4_ply_r);
      s5_den_r  <= s4_den_r;
      s5_ax_r   <= s4_ax_r; s5_ay_r <= s4_ay_r;
    end
  end

  // ---- divide chain: numerator shifted in from the top, QW quotient bits
  // quotient fits QW bits, so the top NW-QW bits seed the partial remainder
  logic [NW-1:0] cnx [NCELL+1], cny [NCELL+1], crx [NCELL+1], cry [NCELL+1], cd [NCELL+1];
  logic [QW-1:0] cqx [NCELL+1], cqy [NCELL+1];
  logic ch [NCELL+1], cp [NCELL+1], cxn [NCELL+1], cyn [NCELL+1];
  d_t cax [NCELL+1], cay [NCELL+1];

  assign cnx[0] = {s5_numx_r[QW-1:0], {(NW-QW){1'b0}}};
  assign cny[0] = {s5_numy_r[QW-1:0], {(NW-QW){1'b0}}};
  assign crx[0] = NW'(s5_numx_r[NW-1:QW]);
  assign cry[0] = NW'(s5_numy_r[NW-1:QW]);
  assign cqx[0] = '0; assign cqy[0] = '0;
  assign cd[0] = s5_den_r;
  assign ch[0] = s5_hit_r; assign cp[0] = s5_pt_r;
  assign cxn[0] = s5_nx_r; assign cyn[0] = s5_ny_r;
  assign cax[0] = s5_ax_r; assign cay[0] = s5_ay_r;

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    siu_div_cell #(.NW(NW), .QW(QW)) u_cell (
      .clk(clk), .en(adv),
      .num_x_i(cnx[g]), .num_y_i(cny[g]), .rem_x_i(crx[g]), .rem_y_i(cry[g]),
      .q_x_i(cqx[g]), .q_y_i(cqy[g]), .den_i(cd[g]),
      .num_x_o(cnx[g+1]), .num_y_o(cny[g+1]), .rem_x_o(crx[g+1]), .rem_y_o(cry[g+1]),
      .q_x_o(cqx[g+1]), .q_y_o(cqy[g+1]), .den_o(cd[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        ch[g+1] <= ch[g]; cp[g+1] <= cp[g];
        cxn[g+1] <= cxn[g]; cyn[g+1] <= cyn[g];
        cax[g+1] <= cax[g]; cay[g+1] <= cay[g];
      end
    end
  end

  // ---- final: start +/- q with truncation toward zero
  logic signed [DW:0] fx, fy;
  always_comb begin
    if (!cxn[NCELL]) begin
      fx = (DW+1)'(cax[NCELL]) + (DW+1)'(cqx[NCELL]);
      if (crx[NCELL] != '0 && fx < 0) fx = fx + (DW+1)'(1);
    end else begin
      fx = (DW+1)'(cax[NCELL]) - (DW+1)'(cqx[NCELL]);
      if (crx[NCELL] != '0 && fx > 0) fx = fx - (DW+1)'(1);
    end
    if (!cyn[NCELL]) begin
      fy = (DW+1)'(cay[NCELL]) + (DW+1)'(cqy[NCELL]);
      if (cry[NCELL] != '0 && fy < 0) fy = fy + (DW+1)'(1);
    end else begin
      fy = (DW+1)'(cay[NCELL]) - (DW+1)'(cqy[NCELL]);
      if (cry[NCELL] != '0 && fy > 0) fy = fy - (DW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit     <= ch[NCELL];
      out_point_x <= cp[NCELL] ? fx[CW-1:0] : '0;
      out_point_y <= cp[NCELL] ? fy[CW-1:0] : '0;
    end
  end

endmodule

@@ bench/segment_intersect_unit_core_checker.sv @@
module segment_intersect_unit_core_checker #(
  parameter int COORD_BITS = siu_pkg::CoordBitsDefault
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic                         in_command,
  input  logic signed [COORD_BITS-1:0] in_start_x,
  input  logic signed [COORD_BITS-1:0] in_start_y,
  input  logic signed [COORD_BITS-1:0] in_end_x,
  input  logic signed [COORD_BITS-1:0] in_end_y,
  input  logic signed [COORD_BITS-1:0] in_other_x0,
  input  logic signed [COORD_BITS-1:0] in_other_y0,
  input  logic signed [COORD_BITS-1:0] in_other_x1,
  input  logic signed [COORD_BITS-1:0] in_other_y1,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_hit,
  input  logic signed [COORD_BITS-1:0] out_point_x,
  input  logic signed [COORD_BITS-1:0] out_point_y,
  output int                           fail_count,
  output int                           pending_count,
  output int                           hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  hit;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
  } crossing_t;

  crossing_t crossing_q[$];

  // exact crossing test on wide integers; point truncated toward zero
  function automatic logic cross_segments(input longint ax, input longint ay,
      input longint bx, input longint by, input longint cx, input longint cy,
      input longint dx, input longint dy, output longint px, output longint py);
    logic signed [127:0] rx, ry, sx, sy, wx, wy, den, nt, nu, qx, qy, mx, my;
    rx = bx - ax; ry = by - ay; sx = dx - cx; sy = dy - cy;
    wx = cx - ax; wy = cy - ay;
    den = rx * sy - ry * sx;
    nt = wx * sy - wy * sx;
    nu = wx * ry - wy * rx;
    px = 0; py = 0;
    if (den == 0) return 1'b0;
    if (den < 0) begin
      den = -den; nt = -nt; nu = -nu;
    end
    if (nt < 0 || nu < 0 || nt > den || nu > den) return 1'b0;
    // a*den + nt*r, divided by den with truncation toward zero
    mx = ax * den + nt * rx;
    my = ay * den + nt * ry;
    qx = mx / den;
    qy = my / den;
    px = longint'(qx);
    py = longint'(qy);
    return 1'b1;
  endfunction

  function automatic crossing_t predict_crossing(input logic cmd,
      input longint ax, input longint ay, input longint bx, input longint by,
      input longint o0, input longint o1, input longint o2, input longint o3);
    crossing_t c;
    longint px, py, l, t, r, b;
    logic h;
    c = '0;
    if (cmd == siu_pkg::CmdSegment) begin
      h = cross_segments(ax, ay, bx, by, o0, o1, o2, o3, px, py);
      c.hit = h;
      if (h) begin
        c.px = px[COORD_BITS-1:0];
        c.py = py[COORD_BITS-1:0];
      end
    end else begin
      l = o0; t = o1; r = o0 + o2; b = o1 + o3;
      c.hit = cross_segments(ax, ay, bx, by, l, t, r, t, px, py)
           || cross_segments(ax, ay, bx, by, r, t, r, b, px, py)
           || cross_segments(ax, ay, bx, by, r, b, l, b, px, py)
           || cross_segments(ax, ay, bx, by, l, b, l, t, px, py);
    end
    return c;
  endfunction

  always @(posedge clk) begin
    crossing_t want;
    if (!rst_n) begin
      fail_count <= 0;
      hit_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        crossing_q.push_back(predict_crossing(in_command, in_start_x, in_start_y,
            in_end_x, in_end_y, in_other_x0, in_other_y0, in_other_x1, in_other_y1));
      if (out_valid && !out_stall) begin
        if (crossing_q.size() == 0) begin
          $display("%0t: unexpected result hit=%0b x=%0d y=%0d", $time, out_hit,
                   out_point_x, out_point_y);
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (out_hit) hit_count <= hit_count + 1;
          if (want.hit !== out_hit || want.px !== out_point_x
              || want.py !== out_point_y) begin
            $display("%0t: mismatch expected hit=%0b x=%0d y=%0d actual hit=%0b x=%0d y=%0d",
                     $time, want.hit, $signed(want.px), $signed(want.py), out_hit,
                     out_point_x, out_point_y);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= crossing_q.size();
  end
endmodule

@@ bench/segment_intersect_unit_core_test.sv @@
module segment_intersect_unit_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = siu_pkg::CoordBitsDefault;
  localparam int LATENCY = CB + 8;
  localparam longint MAX_C = (64'sd1 <<< (CB - 1)) - 1;
  localparam longint MIN_C = -(64'sd1 <<< (CB - 1));
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = siu_pkg::CmdSegment;
  logic signed [CB-1:0] in_start_x = '0, in_start_y = '0, in_end_x = '0, in_end_y = '0;
  logic signed [CB-1:0] in_other_x0 = '0, in_other_y0 = '0;
  logic signed [CB-1:0] in_other_x1 = '0, in_other_y1 = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_hit;
  logic signed [CB-1:0] out_point_x, out_point_y;
  int fail_count, pending_count, hit_count;
  int cycle_count = 0;
  int request_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  segment_intersect_unit_core #(.COORD_BITS(CB)) uut (.*);

  segment_intersect_unit_core_checker #(.COORD_BITS(CB)) checker_i (.*);

  // watchdog on a plain cycle counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stalls at random, changed only on the falling edge
  always @(negedge clk)
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);

  // present one request, optionally idle first, and wait until it is taken
  task automatic send_request(input logic cmd, input longint sx, input longint sy,
      input longint ex, input longint ey, input longint a, input longint b,
      input longint c, input longint d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_start_x <= sx[CB-1:0]; in_start_y <= sy[CB-1:0];
    in_end_x <= ex[CB-1:0]; in_end_y <= ey[CB-1:0];
    in_other_x0 <= a[CB-1:0]; in_other_y0 <= b[CB-1:0];
    in_other_x1 <= c[CB-1:0]; in_other_y1 <= d[CB-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    request_count++;
  endtask

  function automatic longint any_coord();
    return longint'($signed(CB'($urandom())));
  endfunction

  // mostly modest coordinates so segments tend to meet, a few full-range
  function automatic longint near_coord();
    case ($urandom_range(9))
      0: return any_coord();
      1: return ($urandom_range(1)) ? MAX_C : MIN_C;
      default: return longint'($urandom_range(8000)) - 4000;
    endcase
  endfunction

  task automatic random_request();
    longint sx, sy, ex, ey, cx, cy;
    sx = near_coord(); sy = near_coord(); ex = near_coord(); ey = near_coord();
    if ($urandom_range(1)) begin
      // second segment through a random mix of the first one's span
      cx = (sx + ex) / 2;
      cy = (sy + ey) / 2;
      case ($urandom_range(4))
        0: send_request(siu_pkg::CmdSegment, sx, sy, ex, ey, near_coord(), near_coord(),
                        near_coord(), near_coord());
        1: send_request(siu_pkg::CmdSegment, sx, sy, ex, ey, sx, sy, ex, ey);
        default: send_request(siu_pkg::CmdSegment, sx, sy, ex, ey,
                              cx - (ey - sy) / 2, cy + (ex - sx) / 2,
                              cx + (ey - sy) / 2, cy - (ex - sx) / 2);
      endcase
    end else begin
      // rectangle, width and height sometimes negative or zero
      send_request(siu_pkg::CmdRect, sx, sy, ex, ey,
                   longint'($urandom_range(6000)) - 3000,
                   longint'($urandom_range(6000)) - 3000,
                   ($urandom_range(7) == 0) ? any_coord()
                     : longint'($urandom_range(4000)) - 500,
                   ($urandom_range(7) == 0) ? any_coord()
                     : longint'($urandom_range(4000)) - 500);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: plain cross, end-point touch, parallel, collinear, degenerate
    send_request(siu_pkg::CmdSegment, 0, 0, 2560, 2560, 0, 2560, 2560, 0);
    send_request(siu_pkg::CmdSegment, 0, 0, 256, 0, 256, 0, 256, 256);
    send_request(siu_pkg::CmdSegment, 0, 0, 256, 0, 0, 256, 256, 256);
    send_request(siu_pkg::CmdSegment, 0, 0, 256, 0, 128, 0, 512, 0);
    send_request(siu_pkg::CmdSegment, 5, 5, 5, 5, 0, 0, 10, 10);
    send_request(siu_pkg::CmdSegment, -7, 3, 10, -4, -9, -9, 11, 8);
    send_request(siu_pkg::CmdSegment, MIN_C, MIN_C, MAX_C, MAX_C, MIN_C, MAX_C, MAX_C, MIN_C);
    send_request(siu_pkg::CmdSegment, MAX_C, MIN_C, MIN_C, MAX_C, MIN_C, MIN_C, MAX_C, MAX_C);
    send_request(siu_pkg::CmdSegment, MIN_C, 0, MAX_C, 1, 0, MIN_C, 1, MAX_C);
    send_request(siu_pkg::CmdSegment, -1, -1, -1, -1, -1, -1, -1, -1);
    // rectangles: crossing, fully inside, outside, negative size, extreme corners
    send_request(siu_pkg::CmdRect, -100, 50, 1000, 50, 0, 0, 256, 256);
    send_request(siu_pkg::CmdRect, 10, 10, 20, 20, 0, 0, 256, 256);
    send_request(siu_pkg::CmdRect, 1000, 1000, 2000, 2000, 0, 0, 256, 256);
    send_request(siu_pkg::CmdRect, 50, 50, -500, -500, 0, 0, -256, -256);
    send_request(siu_pkg::CmdRect, MIN_C, MIN_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
    send_request(siu_pkg::CmdRect, 0, 0, 0, 0, MIN_C, MIN_C, MIN_C, MIN_C);
    send_request(siu_pkg::CmdRect, 0, -10, 0, 10, 0, 0, 0, 0);
    // hold off until everything in flight has come back
    drain();

    send_idle_pct = 17; recv_idle_pct = 67;
    repeat (450) random_request();
    send_idle_pct = 67; recv_idle_pct = 17;
    repeat (450) random_request();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (450) random_request();

    drain();
    repeat (LATENCY + 10) @(negedge clk);
    $display("covered %0d requests (segment and rectangle, %0d hits) under three idle mixes",
             request_count, hit_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
